[sv/skvt_pkg.sv]
// Shared types and constants for the sorted key/value table.
package skvt_pkg;

   localparam int ACTION_W = 3;
   localparam int KEY_W    = 16;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOOKUP = 3'd0,
      ACT_SET    = 3'd1,
      ACT_REMOVE = 3'd2,
      ACT_CLEAR  = 3'd3,
      ACT_READ   = 3'd4
   } action_type;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_COMPARE = 2'd1,
      ST_SWEEP   = 2'd2,
      ST_COMMIT  = 2'd3
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic cmp_en;     // latch compare results
      logic read_op;    // select by position instead of by key
      logic do_insert;  // open a slot and write the new pair
      logic do_update;  // overwrite value of the matching cell
      logic do_remove;  // close the gap at the matching cell
   } cell_ctl_type;

endpackage

[sv/skvt_cell.sv]
// One storage cell of the sorted chain: holds a pair, compares, shifts and forwards results.
module skvt_cell #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_BITS    = 16,
   parameter int VALUE_BITS  = 32,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                clock,
   input  skvt_pkg::cell_ctl_type              ctl,
   input  logic [KEY_BITS-1:0]                 req_key,
   input  logic [VALUE_BITS-1:0]               req_value,
   input  logic [skvt_pkg::POS_W-1:0]          req_pos,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]    count,
   input  logic [KEY_BITS-1:0]                 left_key,
   input  logic [VALUE_BITS-1:0]               left_value,
   input  logic                                left_lt,
   input  logic [KEY_BITS-1:0]                 right_key,
   input  logic [VALUE_BITS-1:0]               right_value,
   output logic [KEY_BITS-1:0]                 key_o,
   output logic [VALUE_BITS-1:0]               value_o,
   output logic                                lt_o,
   input  logic                                col_hit_i,
   input  logic [KEY_BITS-1:0]                 col_key_i,
   input  logic [VALUE_BITS-1:0]               col_value_i,
   output logic                                col_hit_o,
   output logic [KEY_BITS-1:0]                 col_key_o,
   output logic [VALUE_BITS-1:0]               col_value_o
);
   import skvt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  lt_ff, lt_in;
   logic                  sel_ff, sel_in;
   logic                  col_hit_ff;
   logic [KEY_BITS-1:0]   col_key_ff;
   logic [VALUE_BITS-1:0] col_value_ff;
   logic                  occupied;

   assign occupied = CNT_W'(CELL_INDEX) < count;

   always_comb begin
      lt_in  = lt_ff;
      sel_in = sel_ff;
      if (ctl.cmp_en) begin
         lt_in = occupied && (key_ff < req_key);
         if (ctl.read_op) begin
            sel_in = occupied && (CMP_W'(req_pos) == CMP_W'(CELL_INDEX));
         end else begin
            sel_in = occupied && (key_ff == req_key);
         end
      end
   end

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.do_insert && !lt_ff) begin
         // first cell not below the key takes the new pair, the rest move up
         key_in   = left_lt ? req_key : left_key;
         value_in = left_lt ? req_value : left_value;
      end else if (ctl.do_update && sel_ff) begin
         value_in = req_value;
      end else if (ctl.do_remove && !lt_ff) begin
         key_in   = right_key;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      value_ff     <= value_in;
      lt_ff        <= lt_in;
      sel_ff       <= sel_in;
      // result chain: the selected cell injects its pair, others pass it on
      col_hit_ff   <= sel_ff | col_hit_i;
      col_key_ff   <= sel_ff ? key_ff : col_key_i;
      col_value_ff <= sel_ff ? value_ff : col_value_i;
   end

   assign key_o       = key_ff;
   assign value_o     = value_ff;
   assign lt_o        = lt_ff;
   assign col_hit_o   = col_hit_ff;
   assign col_key_o   = col_key_ff;
   assign col_value_o = col_value_ff;

endmodule

[sv/sorted_key_value_table.sv]
// Sorted key/value table built as a chain of storage cells.
//
// Request channel (req_*): one transaction carries an action with its key, value,
// fallback and position. Result channel (rsp_*): exactly one transaction per request,
// in request order, with found flag, value, key, entry count and status.
// Actions: lookup, set (update or sorted insert), remove, clear, read at position.
//
// Sequence: after a request is taken the cells compare against it, the result
// travels down the cell chain one cell per cycle, and a commit step applies the
// shift and loads the result register. Only one request is in flight at a time:
// a new request is taken only once the previous one has committed.
//
// Reset empties the table (entry count zero); stored pairs are not cleared.
// A stalled result stays in the output register; the next request is still taken
// and runs up to its commit, where it waits until the held result is taken.
module sorted_key_value_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_BITS    = 16,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [skvt_pkg::ACTION_W-1:0]        req_action,
   input  logic [skvt_pkg::KEY_W-1:0]           req_entry_key,
   input  logic [skvt_pkg::VALUE_W-1:0]         req_entry_value,
   input  logic [skvt_pkg::VALUE_W-1:0]         req_fallback_value,
   input  logic [skvt_pkg::POS_W-1:0]           req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [skvt_pkg::VALUE_W-1:0]         rsp_result_value,
   output logic [skvt_pkg::KEY_W-1:0]           rsp_result_key,
   output logic [skvt_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic [skvt_pkg::STATUS_W-1:0]        rsp_status
);
   import skvt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      sweep_ff, sweep_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic [ACTION_W-1:0]   act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_W-1:0]    fb_ff;
   logic [POS_W-1:0]      pos_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic [VALUE_W-1:0]    rval_ff, rval_in;
   logic [KEY_W-1:0]      rkey_ff, rkey_in;
   logic [COUNT_W-1:0]    rcount_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;

   cell_ctl_type          ctl;
   logic                  commit;
   logic                  full;
   logic                  hit;
   logic [KEY_BITS-1:0]   tail_key;
   logic [VALUE_BITS-1:0] tail_value;

   logic [KEY_BITS-1:0]   cell_key   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] cell_value [TABLE_DEPTH];
   logic                  cell_lt    [TABLE_DEPTH];
   logic                  col_hit    [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   col_key    [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] col_value  [TABLE_DEPTH];

   assign req_ready = (state_ff == ST_IDLE);
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign hit        = col_hit[TABLE_DEPTH-1];
   assign tail_key   = col_key[TABLE_DEPTH-1];
   assign tail_value = col_value[TABLE_DEPTH-1];

   // sequencer
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      commit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            sweep_in = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CNT_W'(TABLE_DEPTH - 1)) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // action decode, cell controls and result fields
   always_comb begin
      ctl         = '0;
      ctl.cmp_en  = (state_ff == ST_COMPARE);
      ctl.read_op = (action_type'(act_ff) == ACT_READ);
      count_in    = count_ff;
      found_in    = 1'b0;
      rval_in     = '0;
      rkey_in     = '0;
      status_in   = STATUS_OK;
      case (action_type'(act_ff))
         ACT_LOOKUP: begin
            found_in = hit;
            rval_in  = hit ? VALUE_W'(tail_value) : fb_ff;
         end
         ACT_SET: begin
            found_in = hit;
            if (hit) begin
               ctl.do_update = commit;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               ctl.do_insert = commit;
               count_in      = count_ff + 1'b1;
            end
         end
         ACT_REMOVE: begin
            found_in = hit;
            if (hit) begin
               ctl.do_remove = commit;
               count_in      = count_ff - 1'b1;
            end
         end
         ACT_CLEAR: begin
            count_in = '0;
         end
         ACT_READ: begin
            found_in = hit;
            if (hit) begin
               rval_in = VALUE_W'(tail_value);
               rkey_in = KEY_W'(tail_key);
            end else begin
               status_in = STATUS_BAD_INDEX;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sweep_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         act_ff   <= req_action;
         key_ff   <= KEY_BITS'(req_entry_key);
         value_ff <= VALUE_BITS'(req_entry_value);
         fb_ff    <= req_fallback_value;
         pos_ff   <= req_position;
      end
      if (commit) begin
         found_ff  <= found_in;
         rval_ff   <= rval_in;
         rkey_ff   <= rkey_in;
         rcount_ff <= COUNT_W'(count_in);
         status_ff <= status_in;
      end
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0]   left_key, right_key;
      logic [VALUE_BITS-1:0] left_value, right_value;
      logic                  left_lt;
      logic                  hit_i;
      logic [KEY_BITS-1:0]   ckey_i;
      logic [VALUE_BITS-1:0] cvalue_i;

      if (g == 0) begin : g_first
         assign left_key   = '0;
         assign left_value = '0;
         assign left_lt    = 1'b1;
         assign hit_i      = 1'b0;
         assign ckey_i     = '0;
         assign cvalue_i   = '0;
      end else begin : g_mid
         assign left_key   = cell_key[g-1];
         assign left_value = cell_value[g-1];
         assign left_lt    = cell_lt[g-1];
         assign hit_i      = col_hit[g-1];
         assign ckey_i     = col_key[g-1];
         assign cvalue_i   = col_value[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
         assign right_key   = cell_key[g];
         assign right_value = cell_value[g];
      end else begin : g_inner
         assign right_key   = cell_key[g+1];
         assign right_value = cell_value[g+1];
      end

      skvt_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .KEY_BITS    (KEY_BITS),
         .VALUE_BITS  (VALUE_BITS),
         .CELL_INDEX  (g)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .req_key     (key_ff),
         .req_value   (value_ff),
         .req_pos     (pos_ff),
         .count       (count_ff),
         .left_key    (left_key),
         .left_value  (left_value),
         .left_lt     (left_lt),
         .right_key   (right_key),
         .right_value (right_value),
         .key_o       (cell_key[g]),
         .value_o     (cell_value[g]),
         .lt_o        (cell_lt[g]),
         .col_hit_i   (hit_i),
         .col_key_i   (ckey_i),
         .col_value_i (cvalue_i),
         .col_hit_o   (col_hit[g]),
         .col_key_o   (col_key[g]),
         .col_value_o (col_value[g])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_result_value = rval_ff;
   assign rsp_result_key   = rkey_ff;
   assign rsp_entry_count  = rcount_ff;
   assign rsp_status       = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_count_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      (!reset && !commit) |=> $stable(count_ff))
      else $error("entry count changed outside commit");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("result raised without a commit");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sweep_ff < CNT_W'(TABLE_DEPTH)))
      else $error("sweep ran past the last cell");

endmodule

[dv/sorted_key_value_table_tb.sv]
// Self-checking testbench for the sorted key/value table: random and directed actions.
module sorted_key_value_table_tb;
   import skvt_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int KEY_STRIDE    = 1021;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 3 * (TABLE_DEPTH + 3);
   localparam int ITEM_TARGET   = 450;
   localparam int TAIL_ITEMS    = 60;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
      logic [VALUE_W-1:0]  fallback;
      logic [POS_W-1:0]    position;
   } table_request_type;

   typedef struct {
      logic                found;
      logic [VALUE_W-1:0]  value;
      logic [KEY_W-1:0]    key;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } table_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic [KEY_W-1:0]    req_entry_key = '0;
   logic [VALUE_W-1:0]  req_entry_value = '0;
   logic [VALUE_W-1:0]  req_fallback_value = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic [VALUE_W-1:0]  rsp_result_value;
   logic [KEY_W-1:0]    rsp_result_key;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic [STATUS_W-1:0] rsp_status;

   table_request_type pending_requests[$];
   table_result_type  expected_results[$];
   table_request_type current_req;
   logic           offering = 1'b0;
   int             send_gap = 0;
   int             recv_gap = 0;
   int             hold_left = 0;
   int             hold_asked = 0;
   int             hold_served = 0;
   logic           idle_on = 1'b1;
   int             issued_count = 0;
   int             mismatch_count = 0;
   int             quiet_cycles = 0;

   // Shadow copy of the table contents
   logic [KEY_W-1:0]   model_keys [TABLE_DEPTH];
   logic [VALUE_W-1:0] model_values [TABLE_DEPTH];
   int unsigned        model_fill = 0;

   sorted_key_value_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_BITS(KEY_W),
      .VALUE_BITS(VALUE_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_entry_key(req_entry_key),
      .req_entry_value(req_entry_value),
      .req_fallback_value(req_fallback_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_result_value(rsp_result_value),
      .rsp_result_key(rsp_result_key),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   // Applies one action to the shadow table and returns the result it should produce.
   function automatic table_result_type table_apply(input table_request_type r);
      table_result_type res;
      int unsigned   slot;
      int unsigned   i;
      logic          hit;
      res = '{default: '0};
      slot = 0;
      while (slot < model_fill && model_keys[slot] < r.key) slot++;
      hit = (slot < model_fill) && (model_keys[slot] == r.key);
      case (r.action)
         ACT_LOOKUP: begin
            res.found = hit;
            res.value = hit ? model_values[slot] : r.fallback;
         end
         ACT_SET: begin
            if (hit) begin
               model_values[slot] = r.value;
               res.found = 1'b1;
            end else if (model_fill >= TABLE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = model_fill; i > slot; i--) begin
                  model_keys[i]   = model_keys[i-1];
                  model_values[i] = model_values[i-1];
               end
               model_keys[slot]   = r.key;
               model_values[slot] = r.value;
               model_fill++;
            end
         end
         ACT_REMOVE: begin
            if (hit) begin
               for (i = slot; i + 1 < model_fill; i++) begin
                  model_keys[i]   = model_keys[i+1];
                  model_values[i] = model_values[i+1];
               end
               model_fill--;
               res.found = 1'b1;
            end
         end
         ACT_CLEAR: model_fill = 0;
         ACT_READ: begin
            if (r.position < model_fill) begin
               res.found = 1'b1;
               res.key   = model_keys[r.position];
               res.value = model_values[r.position];
            end else begin
               res.status = STATUS_BAD_INDEX;
            end
         end
         default: ;
      endcase
      res.count = model_fill[COUNT_W-1:0];
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic [VALUE_W-1:0] want,
                                         input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      return KEY_W'($urandom);
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      return POS_W'($urandom);
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         send_gap = 0;
         req_valid <= 1'b0;
      end else begin
         if (offering && req_ready) begin
            expected_results = {expected_results, table_apply(current_req)};
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               if (idle_on && $urandom_range(0, 4) == 0) begin
                  send_gap = $urandom_range(0, 15);
               end else begin
                  current_req = pending_requests.pop_front();
                  req_action         <= current_req.action;
                  req_entry_key      <= current_req.key;
                  req_entry_value    <= current_req.value;
                  req_fallback_value <= current_req.fallback;
                  req_position       <= current_req.position;
                  offering = 1'b1;
               end
            end
         end
         req_valid <= offering;
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin
      table_result_type want;
      logic          ready_next;
      if (reset) begin
         recv_gap = 0;
         hold_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction: found %0h value %0h key %0h count %0d status %0d",
                        $time, rsp_found, rsp_result_value, rsp_result_key, rsp_entry_count,
                        rsp_status);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("found", VALUE_W'(want.found), VALUE_W'(rsp_found));
               compare_field("result_value", want.value, rsp_result_value);
               compare_field("result_key", VALUE_W'(want.key), VALUE_W'(rsp_result_key));
               compare_field("entry_count", VALUE_W'(want.count), VALUE_W'(rsp_entry_count));
               compare_field("status", VALUE_W'(want.status), VALUE_W'(rsp_status));
            end
         end
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            ready_next = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 15);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // Watchdog: ends the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic push_request(input logic [ACTION_W-1:0] action, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value,
                               input logic [VALUE_W-1:0] fallback,
                               input logic [POS_W-1:0] position);
      table_request_type r;
      r.action   = action;
      r.key      = key;
      r.value    = value;
      r.fallback = fallback;
      r.position = position;
      pending_requests = {pending_requests, r};
      issued_count++;
   endtask

   task automatic wait_all_done();
      while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0)
         @(negedge clock);
   endtask

   // Mixed actions on a handful of keys, so hits, updates and removes are common.
   task automatic churn_segment(input int count);
      logic [KEY_W-1:0]    pool [6];
      logic [ACTION_W-1:0] act;
      logic [POS_W-1:0]    pos;
      int                  pick;
      foreach (pool[j]) pool[j] = rand_key();
      if ($urandom_range(0, 1)) begin
         pool[0] = '0;
         pool[1] = '1;
      end
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      act = ACT_SET;
         else if (pick < 60) act = ACT_LOOKUP;
         else if (pick < 80) act = ACT_REMOVE;
         else if (pick < 96) act = ACT_READ;
         else                act = ACT_CLEAR;
         pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 7));
         push_request(act, pool[$urandom_range(0, 5)], $urandom, $urandom, pos);
      end
   endtask

   // Clear, fill the table to the brim, then poke at it while full.
   task automatic fill_segment();
      logic [KEY_W-1:0] keys [TABLE_DEPTH];
      logic [KEY_W-1:0] swap;
      int               base;
      int               j;
      int               k;
      base = $urandom_range(0, 65535 - KEY_STRIDE * (TABLE_DEPTH - 1));
      for (j = 0; j < TABLE_DEPTH; j++) keys[j] = KEY_W'(base + j * KEY_STRIDE);
      for (j = TABLE_DEPTH - 1; j > 0; j--) begin
         k = $urandom_range(0, j);
         swap = keys[j];
         keys[j] = keys[k];
         keys[k] = swap;
      end
      push_request(ACT_CLEAR, rand_key(), $urandom, $urandom, rand_pos());
      for (j = 0; j < TABLE_DEPTH; j++)
         push_request(ACT_SET, keys[j], $urandom, $urandom, rand_pos());
      // keys off the stride grid are new, so these inserts are dropped
      repeat (3)
         push_request(ACT_SET, keys[$urandom_range(0, TABLE_DEPTH - 1)] + 1'b1, $urandom,
                      $urandom, rand_pos());
      push_request(ACT_SET, keys[$urandom_range(0, TABLE_DEPTH - 1)], $urandom, $urandom,
                   rand_pos());
      push_request(ACT_READ, rand_key(), $urandom, $urandom, POS_W'(TABLE_DEPTH - 1));
      push_request(ACT_READ, rand_key(), $urandom, $urandom, '0);
      repeat (3) push_request(ACT_READ, rand_key(), $urandom, $urandom, rand_pos());
      repeat (2) begin
         push_request(ACT_LOOKUP, keys[$urandom_range(0, TABLE_DEPTH - 1)], $urandom, $urandom,
                      rand_pos());
         push_request(ACT_LOOKUP, rand_key(), $urandom, $urandom, rand_pos());
      end
      j = $urandom_range(0, TABLE_DEPTH - 1);
      push_request(ACT_REMOVE, keys[j], $urandom, $urandom, rand_pos());
      push_request(ACT_READ, rand_key(), $urandom, $urandom, POS_W'(TABLE_DEPTH - 1));
      push_request(ACT_SET, keys[j] + 1'b1, $urandom, $urandom, rand_pos());
      push_request(ACT_READ, rand_key(), $urandom, $urandom, rand_pos());
      push_request(ACT_SET, rand_key(), $urandom, $urandom, rand_pos());
   endtask

   task automatic noise_segment(input int count);
      repeat (count)
         push_request(ACTION_W'($urandom_range(ACT_LOOKUP, ACT_READ)), rand_key(), $urandom,
                      $urandom, rand_pos());
   endtask

   initial begin
      logic [ACTION_W-1:0] odd_code;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, key and value extremes, update, miss, bad positions
      push_request(ACT_LOOKUP, '0, '0, '1, '0);
      push_request(ACT_READ, '0, '0, '0, '0);
      push_request(ACT_REMOVE, '1, '0, '0, '0);
      push_request(ACT_SET, '1, '1, '0, '0);
      push_request(ACT_SET, '0, '0, '1, '1);
      push_request(ACT_SET, 16'h8000, 32'hA5A5_A5A5, '0, '0);
      push_request(ACT_SET, 16'h8000, 32'h5A5A_5A5A, '0, '0);
      push_request(ACT_LOOKUP, 16'h8000, '0, '0, '0);
      push_request(ACT_LOOKUP, '1, '0, '0, '0);
      push_request(ACT_READ, '0, '0, '0, '0);
      push_request(ACT_READ, '0, '0, '0, 6'd2);
      push_request(ACT_READ, '0, '0, '0, 6'd3);
      push_request(ACT_READ, '0, '0, '0, '1);
      push_request(ACT_REMOVE, 16'h8000, '0, '0, '0);
      push_request(ACT_REMOVE, 16'h8000, '0, '0, '0);
      push_request(ACT_LOOKUP, 16'h8000, '0, 32'h1234_5678, '0);
      // codes past the last action are ignored by the block
      for (odd_code = ACT_READ + 1'b1; odd_code != '0; odd_code++)
         push_request(odd_code, rand_key(), $urandom, $urandom, rand_pos());
      push_request(ACT_CLEAR, '1, '1, '1, '1);
      push_request(ACT_LOOKUP, '1, '0, 32'hDEAD_BEEF, '0);
      push_request(ACT_READ, '0, '0, '0, '0);
      wait_all_done();

      // Receiver stalls for a long stretch while requests keep coming
      @(negedge clock) hold_asked++;
      churn_segment(16);
      wait_all_done();

      fill_segment();
      while (issued_count < ITEM_TARGET - TAIL_ITEMS) begin
         @(negedge clock) idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 7))
            0:       fill_segment();
            1, 2:    noise_segment($urandom_range(10, 30));
            default: churn_segment($urandom_range(10, 30));
         endcase
         if ($urandom_range(0, 2) == 0) wait_all_done();
      end

      @(negedge clock) idle_on = 1'b0;
      churn_segment(TAIL_ITEMS / 2);
      noise_segment(TAIL_ITEMS / 2);
      wait_all_done();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/skvt_pkg.sv
sv/skvt_cell.sv
sv/sorted_key_value_table.sv
dv/sorted_key_value_table_tb.sv
